### sv/scene_transform_compose_defines.svh
// Assertion macros for the scene transform composer.
// Taken in by the top level; no other dependencies.
`ifndef SCENE_TRANSFORM_COMPOSE_DEFINES_SVH
`define SCENE_TRANSFORM_COMPOSE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define STC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define STC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/stc_pkg.sv
// Shared widths, codes, step table and saturation helper for the
// scene transform composer. No dependencies.
package stc_pkg;

    localparam int QUAT_W     = 16;
    localparam int POS_W      = 32;
    localparam int SCALE_W    = 24;
    localparam int QUAT_FRAC  = QUAT_W - 2;
    localparam int SCALE_FRAC = 16;
    localparam int T_SHIFT    = QUAT_FRAC - 1;

    // Cross-product term width after its rounding shift
    localparam int T_W     = QUAT_W + POS_W + 1 - T_SHIFT;
    localparam int MUL_A_W = (SCALE_W > QUAT_W) ? SCALE_W : QUAT_W;
    localparam int MUL_B_W = (T_W > SCALE_W) ? T_W : SCALE_W;
    localparam int PROD_W  = ((QUAT_W + T_W) > (2 * SCALE_W)) ? (QUAT_W + T_W)
                                                             : (2 * SCALE_W);
    localparam int ACC_W   = PROD_W + 2;
    localparam int RND_W   = ACC_W + 1;
    localparam int SAT_W   = RND_W + 1;

    localparam int NUM_STEPS = 34;
    localparam int RUN_LAST  = NUM_STEPS + 1;
    localparam int CYC_W     = $clog2(RUN_LAST + 1);

    localparam logic signed [RND_W-1:0] HALF_QUAT  = RND_W'(1) << (QUAT_FRAC - 1);
    localparam logic signed [RND_W-1:0] HALF_T     = RND_W'(1) << (T_SHIFT - 1);
    localparam logic signed [RND_W-1:0] HALF_SCALE = RND_W'(1) << (SCALE_FRAC - 1);

    localparam logic signed [SAT_W-1:0] QUAT_MAX  =
        {{(SAT_W - QUAT_W + 1){1'b0}}, {(QUAT_W - 1){1'b1}}};
    localparam logic signed [SAT_W-1:0] POS_MAX   =
        {{(SAT_W - POS_W + 1){1'b0}}, {(POS_W - 1){1'b1}}};
    localparam logic signed [SAT_W-1:0] SCALE_MAX =
        {{(SAT_W - SCALE_W + 1){1'b0}}, {(SCALE_W - 1){1'b1}}};

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_COMPOSE = 2'd1,
        CMD_ROOT    = 2'd2
    } t_cmd;

    // Multiplier operand A: parent quaternion or parent scale
    typedef enum logic [2:0] {
        A_Q0, A_Q1, A_Q2, A_Q3, A_S0, A_S1, A_S2
    } t_asel;

    // Multiplier operand B: local quaternion, position, cross term or scale
    typedef enum logic [3:0] {
        B_Q0, B_Q1, B_Q2, B_Q3, B_V0, B_V1, B_V2, B_T0, B_T1, B_T2, B_S0, B_S1, B_S2
    } t_bsel;

    // What to do with a finished sum
    typedef enum logic [1:0] {
        FIN_ROT, FIN_TMP, FIN_SCL, FIN_POS
    } t_fin;

    typedef struct packed {
        t_asel      asel;
        t_bsel      bsel;
        logic       neg;
        logic       first;
        logic       last;
        t_fin       kind;
        logic [1:0] idx;
    } t_step;

    typedef struct packed {
        logic       valid;
        logic       neg;
        logic       first;
        logic       last;
        t_fin       kind;
        logic [1:0] idx;
    } t_mac_ctl;

    typedef struct packed {
        logic       valid;
        t_fin       kind;
        logic [1:0] idx;
    } t_fin_ctl;

    // Product schedule: Hamilton sums, cross terms, scales, then rotated terms.
    // Scales sit between the cross terms and their use to cover the MAC latency.
    function automatic t_step stc_step(input logic [CYC_W-1:0] s);
        t_step r;
        r = '{A_Q0, B_Q0, 1'b0, 1'b0, 1'b0, FIN_ROT, 2'd0};
        case (s)
            CYC_W'(0):  r = '{A_Q0, B_Q0, 1'b0, 1'b1, 1'b0, FIN_ROT, 2'd0};
            CYC_W'(1):  r = '{A_Q1, B_Q1, 1'b1, 1'b0, 1'b0, FIN_ROT, 2'd0};
            CYC_W'(2):  r = '{A_Q2, B_Q2, 1'b1, 1'b0, 1'b0, FIN_ROT, 2'd0};
            CYC_W'(3):  r = '{A_Q3, B_Q3, 1'b1, 1'b0, 1'b1, FIN_ROT, 2'd0};
            CYC_W'(4):  r = '{A_Q0, B_Q1, 1'b0, 1'b1, 1'b0, FIN_ROT, 2'd1};
            CYC_W'(5):  r = '{A_Q1, B_Q0, 1'b0, 1'b0, 1'b0, FIN_ROT, 2'd1};
            CYC_W'(6):  r = '{A_Q2, B_Q3, 1'b0, 1'b0, 1'b0, FIN_ROT, 2'd1};
            CYC_W'(7):  r = '{A_Q3, B_Q2, 1'b1, 1'b0, 1'b1, FIN_ROT, 2'd1};
            CYC_W'(8):  r = '{A_Q0, B_Q2, 1'b0, 1'b1, 1'b0, FIN_ROT, 2'd2};
            CYC_W'(9):  r = '{A_Q1, B_Q3, 1'b1, 1'b0, 1'b0, FIN_ROT, 2'd2};
            CYC_W'(10): r = '{A_Q2, B_Q0, 1'b0, 1'b0, 1'b0, FIN_ROT, 2'd2};
            CYC_W'(11): r = '{A_Q3, B_Q1, 1'b0, 1'b0, 1'b1, FIN_ROT, 2'd2};
            CYC_W'(12): r = '{A_Q0, B_Q3, 1'b0, 1'b1, 1'b0, FIN_ROT, 2'd3};
            CYC_W'(13): r = '{A_Q1, B_Q2, 1'b0, 1'b0, 1'b0, FIN_ROT, 2'd3};
            CYC_W'(14): r = '{A_Q2, B_Q1, 1'b1, 1'b0, 1'b0, FIN_ROT, 2'd3};
            CYC_W'(15): r = '{A_Q3, B_Q0, 1'b0, 1'b0, 1'b1, FIN_ROT, 2'd3};
            CYC_W'(16): r = '{A_Q2, B_V2, 1'b0, 1'b1, 1'b0, FIN_TMP, 2'd0};
            CYC_W'(17): r = '{A_Q3, B_V1, 1'b1, 1'b0, 1'b1, FIN_TMP, 2'd0};
            CYC_W'(18): r = '{A_Q3, B_V0, 1'b0, 1'b1, 1'b0, FIN_TMP, 2'd1};
            CYC_W'(19): r = '{A_Q1, B_V2, 1'b1, 1'b0, 1'b1, FIN_TMP, 2'd1};
            CYC_W'(20): r = '{A_Q1, B_V1, 1'b0, 1'b1, 1'b0, FIN_TMP, 2'd2};
            CYC_W'(21): r = '{A_Q2, B_V0, 1'b1, 1'b0, 1'b1, FIN_TMP, 2'd2};
            CYC_W'(22): r = '{A_S0, B_S0, 1'b0, 1'b1, 1'b1, FIN_SCL, 2'd0};
            CYC_W'(23): r = '{A_S1, B_S1, 1'b0, 1'b1, 1'b1, FIN_SCL, 2'd1};
            CYC_W'(24): r = '{A_S2, B_S2, 1'b0, 1'b1, 1'b1, FIN_SCL, 2'd2};
            CYC_W'(25): r = '{A_Q0, B_T0, 1'b0, 1'b1, 1'b0, FIN_POS, 2'd0};
            CYC_W'(26): r = '{A_Q2, B_T2, 1'b0, 1'b0, 1'b0, FIN_POS, 2'd0};
            CYC_W'(27): r = '{A_Q3, B_T1, 1'b1, 1'b0, 1'b1, FIN_POS, 2'd0};
            CYC_W'(28): r = '{A_Q0, B_T1, 1'b0, 1'b1, 1'b0, FIN_POS, 2'd1};
            CYC_W'(29): r = '{A_Q3, B_T0, 1'b0, 1'b0, 1'b0, FIN_POS, 2'd1};
            CYC_W'(30): r = '{A_Q1, B_T2, 1'b1, 1'b0, 1'b1, FIN_POS, 2'd1};
            CYC_W'(31): r = '{A_Q0, B_T2, 1'b0, 1'b1, 1'b0, FIN_POS, 2'd2};
            CYC_W'(32): r = '{A_Q1, B_T1, 1'b0, 1'b0, 1'b0, FIN_POS, 2'd2};
            CYC_W'(33): r = '{A_Q2, B_T0, 1'b1, 1'b0, 1'b1, FIN_POS, 2'd2};
            default:    r = '{A_Q0, B_Q0, 1'b0, 1'b0, 1'b0, FIN_ROT, 2'd0};
        endcase
        return r;
    endfunction

    // Clamp to [-(mx+1), mx]
    function automatic logic signed [SAT_W-1:0] sat_clip(
        input logic signed [SAT_W-1:0] x,
        input logic signed [SAT_W-1:0] mx
    );
        logic signed [SAT_W-1:0] r;
        if (x > mx) begin
            r = mx;
        end else if (x < ~mx) begin
            r = ~mx;
        end else begin
            r = x;
        end
        return r;
    endfunction

endpackage

### sv/stc_in_if.sv
// Input channel of the scene transform composer: valid/ready plus one transform.
// Depends on stc_pkg.
interface stc_in_if import stc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [1:0]                cmd;
    logic signed [QUAT_W-1:0]  rot_w;
    logic signed [QUAT_W-1:0]  rot_x;
    logic signed [QUAT_W-1:0]  rot_y;
    logic signed [QUAT_W-1:0]  rot_z;
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
    logic signed [POS_W-1:0]   pos_z;
    logic signed [SCALE_W-1:0] scale_x;
    logic signed [SCALE_W-1:0] scale_y;
    logic signed [SCALE_W-1:0] scale_z;

    modport source (
        output valid, cmd, rot_w, rot_x, rot_y, rot_z,
               pos_x, pos_y, pos_z, scale_x, scale_y, scale_z,
        input  ready
    );
    modport sink (
        input  valid, cmd, rot_w, rot_x, rot_y, rot_z,
               pos_x, pos_y, pos_z, scale_x, scale_y, scale_z,
        output ready
    );
endinterface

### sv/stc_out_if.sv
// Output channel of the scene transform composer: valid/ready plus one world
// transform. Depends on stc_pkg.
interface stc_out_if import stc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [QUAT_W-1:0]  out_rot_w;
    logic signed [QUAT_W-1:0]  out_rot_x;
    logic signed [QUAT_W-1:0]  out_rot_y;
    logic signed [QUAT_W-1:0]  out_rot_z;
    logic signed [POS_W-1:0]   out_pos_x;
    logic signed [POS_W-1:0]   out_pos_y;
    logic signed [POS_W-1:0]   out_pos_z;
    logic signed [SCALE_W-1:0] out_scale_x;
    logic signed [SCALE_W-1:0] out_scale_y;
    logic signed [SCALE_W-1:0] out_scale_z;

    modport source (
        output valid, out_rot_w, out_rot_x, out_rot_y, out_rot_z,
               out_pos_x, out_pos_y, out_pos_z, out_scale_x, out_scale_y, out_scale_z,
        input  ready
    );
    modport sink (
        input  valid, out_rot_w, out_rot_x, out_rot_y, out_rot_z,
               out_pos_x, out_pos_y, out_pos_z, out_scale_x, out_scale_y, out_scale_z,
        output ready
    );
endinterface

### sv/stc_mac.sv
// Shared multiply-accumulate unit: registered product, then signed accumulate.
// Depends on stc_pkg for widths and control structs.
module stc_mac import stc_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic signed [MUL_A_W-1:0] i_a,
    input  logic signed [MUL_B_W-1:0] i_b,
    input  t_mac_ctl                 i_ctl,
    output logic signed [ACC_W-1:0]  o_acc,
    output t_fin_ctl                 o_fin
);

    logic signed [MUL_A_W+MUL_B_W-1:0] w_full;
    logic signed [PROD_W-1:0]          r_prod;
    t_mac_ctl                          r_pctl;
    logic signed [ACC_W-1:0]           r_acc;
    logic signed [ACC_W-1:0]           n_acc;
    logic signed [ACC_W-1:0]           w_base;
    logic signed [ACC_W-1:0]           w_prod_x;
    t_fin_ctl                          r_fin;

    assign w_full = i_a * i_b;

    always_comb begin
        w_prod_x = ACC_W'(r_prod);
        w_base   = r_pctl.first ? '0 : r_acc;
        n_acc    = r_pctl.neg ? (w_base - w_prod_x) : (w_base + w_prod_x);
    end

    always_ff @(posedge i_clk) begin
        // operand values never use the top bits of the full product
        r_prod <= w_full[PROD_W-1:0];
        if (r_pctl.valid) begin
            r_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pctl <= '0;
            r_fin  <= '0;
        end else begin
            r_pctl      <= i_ctl;
            r_fin.valid <= r_pctl.valid && r_pctl.last;
            r_fin.kind  <= r_pctl.kind;
            r_fin.idx   <= r_pctl.idx;
        end
    end

    assign o_acc = r_acc;
    assign o_fin = r_fin;

endmodule

### sv/scene_transform_compose.sv
// Top level of the scene transform composer: parent state, sequencer, result
// registers. Depends on stc_pkg, stc_in_if, stc_out_if, stc_mac and the defines header.
//
// Each transfer on i_in carries a command and one transform. Load (cmd 0) stores
// the transform as the parent world transform and gives no result; an undefined
// command is dropped. Root (cmd 2) copies the input to the result register. Compose
// (cmd 1) runs 34 products through a single 24x36 multiplier with an accumulator
// behind it, one product a cycle: 16 for the Hamilton product, 6 for the cross
// term, 3 for scale, 9 for the rotated position. The input is ready again the
// cycle after the result is taken, so no new transfer is accepted while a compose
// runs or a result waits. Compose results are rounded half up and saturated to
// their field widths. The parent resets to the identity transform with unit scale.
`include "scene_transform_compose_defines.svh"

module scene_transform_compose import stc_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    stc_in_if.sink        i_in,
    stc_out_if.source     o_out
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state                    r_state;
    t_state                    n_state;
    logic [CYC_W-1:0]          r_cyc;
    logic [CYC_W-1:0]          n_cyc;

    logic signed [QUAT_W-1:0]  r_par_rot [0:3];
    logic signed [POS_W-1:0]   r_par_pos [0:2];
    logic signed [SCALE_W-1:0] r_par_scl [0:2];

    logic signed [QUAT_W-1:0]  r_q [0:3];
    logic signed [POS_W-1:0]   r_v [0:2];
    logic signed [SCALE_W-1:0] r_s [0:2];
    logic signed [T_W-1:0]     r_t [0:2];

    logic signed [QUAT_W-1:0]  r_res_rot [0:3];
    logic signed [POS_W-1:0]   r_res_pos [0:2];
    logic signed [SCALE_W-1:0] r_res_scl [0:2];

    logic                      w_in_xfer;
    logic                      w_out_xfer;
    t_step                     w_step;
    t_mac_ctl                  w_ctl;
    logic signed [MUL_A_W-1:0] w_a;
    logic signed [MUL_B_W-1:0] w_b;
    logic signed [ACC_W-1:0]   w_acc;
    t_fin_ctl                  w_fin;

    logic signed [RND_W-1:0]   w_acc_x;
    logic signed [RND_W-1:0]   w_half;
    logic signed [RND_W-1:0]   w_sum;
    logic signed [RND_W-1:0]   w_rnd;
    logic signed [SAT_W-1:0]   w_rnd_x;
    logic signed [SAT_W-1:0]   w_pos;

    assign w_in_xfer  = i_in.valid && i_in.ready;
    assign w_out_xfer = o_out.valid && o_out.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign o_out.valid = (r_state == S_DONE);

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_cyc   = r_cyc;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    unique case (i_in.cmd)
                        CMD_COMPOSE: begin
                            n_state = S_RUN;
                            n_cyc   = '0;
                        end
                        CMD_ROOT: n_state = S_DONE;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_RUN: begin
                n_cyc = r_cyc + CYC_W'(1);
                if (r_cyc == CYC_W'(RUN_LAST)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_xfer) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Issue one product a cycle
    always_comb begin
        w_step      = stc_step(r_cyc);
        w_ctl.valid = (r_state == S_RUN) && (r_cyc < CYC_W'(NUM_STEPS));
        w_ctl.neg   = w_step.neg;
        w_ctl.first = w_step.first;
        w_ctl.last  = w_step.last;
        w_ctl.kind  = w_step.kind;
        w_ctl.idx   = w_step.idx;

        unique case (w_step.asel)
            A_Q0:    w_a = MUL_A_W'(r_par_rot[0]);
            A_Q1:    w_a = MUL_A_W'(r_par_rot[1]);
            A_Q2:    w_a = MUL_A_W'(r_par_rot[2]);
            A_Q3:    w_a = MUL_A_W'(r_par_rot[3]);
            A_S0:    w_a = MUL_A_W'(r_par_scl[0]);
            A_S1:    w_a = MUL_A_W'(r_par_scl[1]);
            A_S2:    w_a = MUL_A_W'(r_par_scl[2]);
            default: w_a = '0;
        endcase

        unique case (w_step.bsel)
            B_Q0:    w_b = MUL_B_W'(r_q[0]);
            B_Q1:    w_b = MUL_B_W'(r_q[1]);
            B_Q2:    w_b = MUL_B_W'(r_q[2]);
            B_Q3:    w_b = MUL_B_W'(r_q[3]);
            B_V0:    w_b = MUL_B_W'(r_v[0]);
            B_V1:    w_b = MUL_B_W'(r_v[1]);
            B_V2:    w_b = MUL_B_W'(r_v[2]);
            B_T0:    w_b = MUL_B_W'(r_t[0]);
            B_T1:    w_b = MUL_B_W'(r_t[1]);
            B_T2:    w_b = MUL_B_W'(r_t[2]);
            B_S0:    w_b = MUL_B_W'(r_s[0]);
            B_S1:    w_b = MUL_B_W'(r_s[1]);
            B_S2:    w_b = MUL_B_W'(r_s[2]);
            default: w_b = '0;
        endcase
    end

    stc_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_a     (w_a),
        .i_b     (w_b),
        .i_ctl   (w_ctl),
        .o_acc   (w_acc),
        .o_fin   (w_fin)
    );

    // Round half up, then shift down to the result's fraction; a position sum also adds the parent and local position
    always_comb begin
        w_acc_x = RND_W'(w_acc);
        case (w_fin.kind)
            FIN_TMP: w_half = HALF_T;
            FIN_SCL: w_half = HALF_SCALE;
            default: w_half = HALF_QUAT;
        endcase
        w_sum = w_acc_x + w_half;
        case (w_fin.kind)
            FIN_TMP: w_rnd = w_sum >>> T_SHIFT;
            FIN_SCL: w_rnd = w_sum >>> SCALE_FRAC;
            default: w_rnd = w_sum >>> QUAT_FRAC;
        endcase
        w_rnd_x = SAT_W'(w_rnd);
        w_pos   = w_rnd_x + SAT_W'(r_par_pos[w_fin.idx]) + SAT_W'(r_v[w_fin.idx]);
    end

    // Control and parent state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cyc        <= '0;
            r_par_rot[0] <= QUAT_W'(1) << QUAT_FRAC;
            r_par_rot[1] <= '0;
            r_par_rot[2] <= '0;
            r_par_rot[3] <= '0;
            for (int i = 0; i < 3; i++) begin
                r_par_pos[i] <= '0;
                r_par_scl[i] <= SCALE_W'(1) << SCALE_FRAC;
            end
        end else begin
            r_state <= n_state;
            r_cyc   <= n_cyc;
            if (w_in_xfer && (i_in.cmd == CMD_LOAD)) begin
                r_par_rot[0] <= i_in.rot_w;
                r_par_rot[1] <= i_in.rot_x;
                r_par_rot[2] <= i_in.rot_y;
                r_par_rot[3] <= i_in.rot_z;
                r_par_pos[0] <= i_in.pos_x;
                r_par_pos[1] <= i_in.pos_y;
                r_par_pos[2] <= i_in.pos_z;
                r_par_scl[0] <= i_in.scale_x;
                r_par_scl[1] <= i_in.scale_y;
                r_par_scl[2] <= i_in.scale_z;
            end
        end
    end

    // Operand, cross-term and result registers
    always_ff @(posedge i_clk) begin
        if (w_in_xfer && (i_in.cmd == CMD_COMPOSE)) begin
            r_q[0] <= i_in.rot_w;
            r_q[1] <= i_in.rot_x;
            r_q[2] <= i_in.rot_y;
            r_q[3] <= i_in.rot_z;
            r_v[0] <= i_in.pos_x;
            r_v[1] <= i_in.pos_y;
            r_v[2] <= i_in.pos_z;
            r_s[0] <= i_in.scale_x;
            r_s[1] <= i_in.scale_y;
            r_s[2] <= i_in.scale_z;
        end
        if (w_in_xfer && (i_in.cmd == CMD_ROOT)) begin
            r_res_rot[0] <= i_in.rot_w;
            r_res_rot[1] <= i_in.rot_x;
            r_res_rot[2] <= i_in.rot_y;
            r_res_rot[3] <= i_in.rot_z;
            r_res_pos[0] <= i_in.pos_x;
            r_res_pos[1] <= i_in.pos_y;
            r_res_pos[2] <= i_in.pos_z;
            r_res_scl[0] <= i_in.scale_x;
            r_res_scl[1] <= i_in.scale_y;
            r_res_scl[2] <= i_in.scale_z;
        end
        if (w_fin.valid) begin
            case (w_fin.kind)
                FIN_ROT: r_res_rot[w_fin.idx] <= QUAT_W'(sat_clip(w_rnd_x, QUAT_MAX));
                FIN_TMP: r_t[w_fin.idx]       <= T_W'(w_rnd);
                FIN_SCL: r_res_scl[w_fin.idx] <= SCALE_W'(sat_clip(w_rnd_x, SCALE_MAX));
                default: r_res_pos[w_fin.idx] <= POS_W'(sat_clip(w_pos, POS_MAX));
            endcase
        end
    end

    assign o_out.out_rot_w   = r_res_rot[0];
    assign o_out.out_rot_x   = r_res_rot[1];
    assign o_out.out_rot_y   = r_res_rot[2];
    assign o_out.out_rot_z   = r_res_rot[3];
    assign o_out.out_pos_x   = r_res_pos[0];
    assign o_out.out_pos_y   = r_res_pos[1];
    assign o_out.out_pos_z   = r_res_pos[2];
    assign o_out.out_scale_x = r_res_scl[0];
    assign o_out.out_scale_y = r_res_scl[1];
    assign o_out.out_scale_z = r_res_scl[2];

    `STC_ASSERT_NOW(a_fin_in_run, i_clk, i_rst_n, w_fin.valid, r_state == S_RUN, "finished sum outside a compose run")
    `STC_ASSERT_NEXT(a_run_end, i_clk, i_rst_n, (r_state == S_RUN) && (r_cyc == CYC_W'(RUN_LAST)), r_state == S_DONE, "compose run did not end with a result")
    `STC_ASSERT_NEXT(a_compose_start, i_clk, i_rst_n, w_in_xfer && (i_in.cmd == CMD_COMPOSE), (r_state == S_RUN) && (r_cyc == '0), "compose transfer did not start a run")

endmodule

### verif/tb_scene_transform_compose.sv
// Self-checking bench for scene_transform_compose: drives parent loads, composes,
// root transforms and undefined commands, and checks every world transform.
// Depends on stc_pkg, stc_in_if, stc_out_if and the block itself.
`timescale 1ns / 100ps

module tb_scene_transform_compose;
    import stc_pkg::*;

    localparam logic [1:0] CMD_UNDEF = 2'd3;

    localparam longint Q_MAX = (longint'(1) << (QUAT_W - 1)) - 1;
    localparam longint Q_MIN = -Q_MAX - 1;
    localparam longint P_MAX = (longint'(1) << (POS_W - 1)) - 1;
    localparam longint P_MIN = -P_MAX - 1;
    localparam longint S_MAX = (longint'(1) << (SCALE_W - 1)) - 1;
    localparam longint S_MIN = -S_MAX - 1;
    localparam int     Q_ONE = 1 << QUAT_FRAC;
    localparam int     S_ONE = 1 << SCALE_FRAC;
    localparam int     P_ONE = 1 << 16;
    localparam int     C45   = 11585;   // cos(45 deg) in Q2.14

    localparam int N_ITEMS   = 850;
    localparam int IDLE_PCT  = 28;
    localparam int N_FIELDS  = 10;
    localparam int MAX_SHOWN = 10;
    localparam int SETTLE    = 48;

    typedef struct packed {
        logic [1:0]                cmd;
        logic signed [QUAT_W-1:0]  rw, rx, ry, rz;
        logic signed [POS_W-1:0]   px, py, pz;
        logic signed [SCALE_W-1:0] sx, sy, sz;
    } xform_t;

    typedef struct packed {
        logic signed [QUAT_W-1:0]  rw, rx, ry, rz;
        logic signed [POS_W-1:0]   px, py, pz;
        logic signed [SCALE_W-1:0] sx, sy, sz;
    } world_t;

    localparam string FIELD_NAME [N_FIELDS] = '{
        "rot_w", "rot_x", "rot_y", "rot_z", "pos_x", "pos_y", "pos_z",
        "scale_x", "scale_y", "scale_z"
    };

    logic i_clk;
    logic i_rst_n;

    stc_in_if  in_ch ();
    stc_out_if out_ch ();

    scene_transform_compose u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Parent world transform as the block should hold it
    longint par_rot [4];
    longint par_pos [3];
    longint par_scl [3];

    xform_t node_feed [$];
    world_t world_due [$];
    xform_t cur_xf;

    int mismatches   = 0;
    int n_checked    = 0;
    int n_load       = 0;
    int n_compose    = 0;
    int n_root       = 0;
    int n_undef      = 0;
    int accepted_cnt = 0;

    logic calm;
    assign calm = (accepted_cnt >= 300) && (accepted_cnt < 450);

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    function automatic longint round_half_up(input longint x, input int s);
        return (x + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clamp(input longint x, input int w);
        longint hi;
        longint lo;
        hi = (longint'(1) << (w - 1)) - 1;
        lo = -hi - 1;
        if (x > hi) return hi;
        if (x < lo) return lo;
        return x;
    endfunction

    // Update the parent and queue the world transform that this transfer yields
    task automatic track_node(input xform_t it);
        longint q [4];
        longint v [3];
        longint s [3];
        longint r [4];
        longint t [3];
        longint u [3];
        longint p [3];
        longint sc [3];
        world_t w;
        q[0] = longint'(it.rw); q[1] = longint'(it.rx);
        q[2] = longint'(it.ry); q[3] = longint'(it.rz);
        v[0] = longint'(it.px); v[1] = longint'(it.py); v[2] = longint'(it.pz);
        s[0] = longint'(it.sx); s[1] = longint'(it.sy); s[2] = longint'(it.sz);
        case (it.cmd)
            CMD_LOAD: begin
                for (int i = 0; i < 4; i++) par_rot[i] = q[i];
                for (int i = 0; i < 3; i++) begin
                    par_pos[i] = v[i];
                    par_scl[i] = s[i];
                end
                n_load++;
            end
            CMD_ROOT: begin
                w = '{rw: it.rw, rx: it.rx, ry: it.ry, rz: it.rz,
                      px: it.px, py: it.py, pz: it.pz,
                      sx: it.sx, sy: it.sy, sz: it.sz};
                world_due.push_back(w);
                n_root++;
            end
            CMD_COMPOSE: begin
                r[0] = par_rot[0]*q[0] - par_rot[1]*q[1] - par_rot[2]*q[2] - par_rot[3]*q[3];
                r[1] = par_rot[0]*q[1] + par_rot[1]*q[0] + par_rot[2]*q[3] - par_rot[3]*q[2];
                r[2] = par_rot[0]*q[2] - par_rot[1]*q[3] + par_rot[2]*q[0] + par_rot[3]*q[1];
                r[3] = par_rot[0]*q[3] + par_rot[1]*q[2] - par_rot[2]*q[1] + par_rot[3]*q[0];
                for (int i = 0; i < 4; i++) r[i] = clamp(round_half_up(r[i], QUAT_FRAC), QUAT_W);
                // Twice the cross product lands in Q.16 after a 13-bit shift, unclamped
                t[0] = round_half_up(par_rot[2]*v[2] - par_rot[3]*v[1], QUAT_FRAC - 1);
                t[1] = round_half_up(par_rot[3]*v[0] - par_rot[1]*v[2], QUAT_FRAC - 1);
                t[2] = round_half_up(par_rot[1]*v[1] - par_rot[2]*v[0], QUAT_FRAC - 1);
                u[0] = par_rot[0]*t[0] + par_rot[2]*t[2] - par_rot[3]*t[1];
                u[1] = par_rot[0]*t[1] + par_rot[3]*t[0] - par_rot[1]*t[2];
                u[2] = par_rot[0]*t[2] + par_rot[1]*t[1] - par_rot[2]*t[0];
                for (int i = 0; i < 3; i++) begin
                    p[i]  = clamp(par_pos[i] + v[i] + round_half_up(u[i], QUAT_FRAC), POS_W);
                    sc[i] = clamp(round_half_up(par_scl[i] * s[i], SCALE_FRAC), SCALE_W);
                end
                w.rw = QUAT_W'(r[0]);  w.rx = QUAT_W'(r[1]);
                w.ry = QUAT_W'(r[2]);  w.rz = QUAT_W'(r[3]);
                w.px = POS_W'(p[0]);   w.py = POS_W'(p[1]);   w.pz = POS_W'(p[2]);
                w.sx = SCALE_W'(sc[0]); w.sy = SCALE_W'(sc[1]); w.sz = SCALE_W'(sc[2]);
                world_due.push_back(w);
                n_compose++;
            end
            default: n_undef++;
        endcase
    endtask

    function automatic logic signed [63:0] world_field(input world_t w, input int i);
        logic signed [63:0] f;
        case (i)
            0:       f = 64'(w.rw);
            1:       f = 64'(w.rx);
            2:       f = 64'(w.ry);
            3:       f = 64'(w.rz);
            4:       f = 64'(w.px);
            5:       f = 64'(w.py);
            6:       f = 64'(w.pz);
            7:       f = 64'(w.sx);
            8:       f = 64'(w.sy);
            default: f = 64'(w.sz);
        endcase
        return f;
    endfunction

    task automatic check_world(input world_t got);
        world_t want;
        if (world_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
                $display("%t: world transform arrived with none outstanding", $time);
        end else begin
            want = world_due.pop_front();
            n_checked++;
            for (int i = 0; i < N_FIELDS; i++) begin
                if (world_field(got, i) !== world_field(want, i)) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("%t: result %0d %s expected %0d got %0d", $time,
                                 n_checked, FIELD_NAME[i], world_field(want, i),
                                 world_field(got, i));
                end
            end
        end
    endtask

    function automatic xform_t node_xf(input logic [1:0] c,
                                       input longint rw, rx, ry, rz,
                                       input longint px, py, pz,
                                       input longint sx, sy, sz);
        xform_t x;
        x.cmd = c;
        x.rw = QUAT_W'(rw);   x.rx = QUAT_W'(rx);   x.ry = QUAT_W'(ry);   x.rz = QUAT_W'(rz);
        x.px = POS_W'(px);    x.py = POS_W'(py);    x.pz = POS_W'(pz);
        x.sx = SCALE_W'(sx);  x.sy = SCALE_W'(sy);  x.sz = SCALE_W'(sz);
        return x;
    endfunction

    function automatic longint rand_quat();
        case ($urandom_range(0, 7))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2, 3:    return longint'($signed(QUAT_W'($urandom)));
            default: return longint'($urandom_range(0, 2 * Q_ONE)) - Q_ONE;
        endcase
    endfunction

    function automatic longint rand_pos();
        case ($urandom_range(0, 7))
            0:       return P_MAX;
            1:       return P_MIN;
            2, 3:    return longint'($signed(POS_W'($urandom)));
            default: return longint'($urandom_range(0, 1 << 24)) - (1 << 23);
        endcase
    endfunction

    function automatic longint rand_scale();
        case ($urandom_range(0, 7))
            0:       return S_MAX;
            1:       return S_MIN;
            2, 3:    return longint'($signed(SCALE_W'($urandom)));
            default: return longint'($urandom_range(0, 1 << 19)) - (1 << 18);
        endcase
    endfunction

    function automatic xform_t rand_xf(input logic [1:0] c);
        return node_xf(c, rand_quat(), rand_quat(), rand_quat(), rand_quat(),
                       rand_pos(), rand_pos(), rand_pos(),
                       rand_scale(), rand_scale(), rand_scale());
    endfunction

    // Hold the sender until every queued transfer is taken and every result is back
    task automatic drain();
        while (node_feed.size() != 0 || in_ch.valid || world_due.size() != 0)
            @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin : drive_in
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                track_node(cur_xf);
                accepted_cnt++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (node_feed.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    cur_xf = node_feed.pop_front();
                    in_ch.valid   <= 1'b1;
                    in_ch.cmd     <= cur_xf.cmd;
                    in_ch.rot_w   <= cur_xf.rw;
                    in_ch.rot_x   <= cur_xf.rx;
                    in_ch.rot_y   <= cur_xf.ry;
                    in_ch.rot_z   <= cur_xf.rz;
                    in_ch.pos_x   <= cur_xf.px;
                    in_ch.pos_y   <= cur_xf.py;
                    in_ch.pos_z   <= cur_xf.pz;
                    in_ch.scale_x <= cur_xf.sx;
                    in_ch.scale_y <= cur_xf.sy;
                    in_ch.scale_z <= cur_xf.sz;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watch_out
        world_t got;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got = '{rw: out_ch.out_rot_w, rx: out_ch.out_rot_x,
                        ry: out_ch.out_rot_y, rz: out_ch.out_rot_z,
                        px: out_ch.out_pos_x, py: out_ch.out_pos_y, pz: out_ch.out_pos_z,
                        sx: out_ch.out_scale_x, sy: out_ch.out_scale_y,
                        sz: out_ch.out_scale_z};
                check_world(got);
            end
            out_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial begin : watchdog
        #5_000_000;
        $display("Run timed out with %0d results outstanding", world_due.size());
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        int  sent;
        int  pick;
        int  run_len;
        bit  paused;
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.cmd     = CMD_LOAD;
        in_ch.rot_w   = '0;
        in_ch.rot_x   = '0;
        in_ch.rot_y   = '0;
        in_ch.rot_z   = '0;
        in_ch.pos_x   = '0;
        in_ch.pos_y   = '0;
        in_ch.pos_z   = '0;
        in_ch.scale_x = '0;
        in_ch.scale_y = '0;
        in_ch.scale_z = '0;
        out_ch.ready  = 1'b0;

        par_rot[0] = Q_ONE;
        for (int i = 1; i < 4; i++) par_rot[i] = 0;
        for (int i = 0; i < 3; i++) begin
            par_pos[i] = 0;
            par_scl[i] = S_ONE;
        end

        // Composes against the reset parent, with root and undefined commands between them
        node_feed.push_back(node_xf(CMD_COMPOSE, Q_ONE, 0, 0, 0, P_MAX, P_MIN, P_ONE,
                                    S_MAX, S_MIN, S_ONE));
        node_feed.push_back(node_xf(CMD_ROOT, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                                    P_MAX, P_MAX, P_MAX, S_MAX, S_MAX, S_MAX));
        node_feed.push_back(node_xf(CMD_ROOT, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                                    P_MIN, P_MIN, P_MIN, S_MIN, S_MIN, S_MIN));
        node_feed.push_back(node_xf(CMD_UNDEF, Q_MAX, Q_MIN, 0, 0, P_MAX, 0, 0, S_MIN, 0, 0));
        node_feed.push_back(node_xf(CMD_COMPOSE, 0, Q_ONE, 0, 0, P_ONE, 2 * P_ONE, 3 * P_ONE,
                                    S_ONE, S_ONE, S_ONE));
        // Parents at both extremes; extreme composes saturate rotation and scale
        node_feed.push_back(node_xf(CMD_LOAD, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                                    P_MAX, P_MAX, P_MAX, S_MAX, S_MAX, S_MAX));
        node_feed.push_back(node_xf(CMD_COMPOSE, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                                    P_MAX, P_MAX, P_MAX, S_MAX, S_MAX, S_MAX));
        node_feed.push_back(node_xf(CMD_COMPOSE, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                                    P_MIN, P_MIN, P_MIN, S_MIN, S_MIN, S_MIN));
        node_feed.push_back(node_xf(CMD_LOAD, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                                    P_MIN, P_MIN, P_MIN, S_MIN, S_MIN, S_MIN));
        node_feed.push_back(node_xf(CMD_COMPOSE, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                                    P_MAX, P_MAX, P_MAX, S_MAX, S_MAX, S_MAX));
        node_feed.push_back(node_xf(CMD_COMPOSE, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                                    P_MIN, P_MIN, P_MIN, S_MIN, S_MIN, S_MIN));
        node_feed.push_back(node_xf(CMD_COMPOSE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // Quarter turn about z with offset and doubled scale
        node_feed.push_back(node_xf(CMD_LOAD, C45, 0, 0, C45, P_ONE, 2 * P_ONE, 3 * P_ONE,
                                    2 * S_ONE, 2 * S_ONE, 2 * S_ONE));
        node_feed.push_back(node_xf(CMD_COMPOSE, Q_ONE, 0, 0, 0, P_ONE, 0, 0,
                                    S_ONE / 2, S_ONE / 2, S_ONE / 2));
        node_feed.push_back(node_xf(CMD_COMPOSE, C45, C45, 0, 0, 0, P_ONE, -P_ONE,
                                    S_ONE, -S_ONE, S_ONE));
        node_feed.push_back(node_xf(CMD_UNDEF, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                                    P_MAX, P_MAX, P_MAX, S_MAX, S_MAX, S_MAX));
        node_feed.push_back(node_xf(CMD_COMPOSE, Q_ONE, 0, 0, 0, 0, 0, P_ONE,
                                    S_ONE, S_ONE, S_ONE));
        // Exact half-LSB ties in the rotation and scale rounding, both signs
        node_feed.push_back(node_xf(CMD_LOAD, 1, 0, 0, 0, 1, -1, 0, 1, -1, 3));
        node_feed.push_back(node_xf(CMD_COMPOSE, Q_ONE / 2, -Q_ONE / 2, Q_ONE / 2, 0,
                                    P_MAX, P_MIN, 0, S_ONE / 2, S_ONE / 2, -S_ONE / 2));
        // Ties in the cross-term rounding
        node_feed.push_back(node_xf(CMD_LOAD, Q_ONE, 1, 0, 0, 0, 0, 0, S_ONE, S_ONE, S_ONE));
        node_feed.push_back(node_xf(CMD_COMPOSE, Q_ONE, 0, 0, 0, 0, 1 << (T_SHIFT - 1),
                                    -(1 << (T_SHIFT - 1)), S_ONE, S_ONE, S_ONE));
        node_feed.push_back(node_xf(CMD_ROOT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        drain();

        // Mostly a load followed by a run of composes; the rest is loose noise
        sent   = 0;
        paused = 1'b0;
        while (sent < N_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                run_len = $urandom_range(1, 5);
                node_feed.push_back(rand_xf(CMD_LOAD));
                repeat (run_len) node_feed.push_back(rand_xf(CMD_COMPOSE));
                sent += run_len + 1;
            end else if (pick < 75) begin
                node_feed.push_back(rand_xf(CMD_ROOT));
                sent++;
            end else if (pick < 85) begin
                node_feed.push_back(rand_xf(CMD_COMPOSE));
                sent++;
            end else if (pick < 92) begin
                node_feed.push_back(rand_xf(CMD_UNDEF));
            end else begin
                node_feed.push_back(rand_xf(CMD_LOAD));
                sent++;
            end
            if (!paused && sent >= N_ITEMS / 2) begin
                paused = 1'b1;
                drain();
            end
        end

        drain();
        repeat (SETTLE) @(negedge i_clk);

        $display("Covered %0d parent loads, %0d composes, %0d root transforms",
                 n_load, n_compose, n_root);
        $display("and %0d undefined commands; %0d world transforms compared, %0d bad fields",
                 n_undef, n_checked, mismatches);
        if (world_due.size() != 0)
            $display("%0d world transforms never arrived", world_due.size());
        if (mismatches == 0 && world_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
